/* rtl/lsps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_pkg
// Shared types, constants and helpers of the LED strip pixel serializer.
// ----------------------------------------------------------------------------
package lsps_pkg;

    localparam int LED_MAX  = 256;
    localparam int IDX_W    = $clog2(LED_MAX);
    localparam int CNT_W    = IDX_W + 1;
    localparam int DUR_W    = 15;
    localparam int PIX_W    = 24;
    localparam int BIT_W    = 5;
    localparam int CFG_IDX_W = 3;

    // command kinds
    localparam logic [2:0] K_WRITE   = 3'd0;
    localparam logic [2:0] K_FILL    = 3'd1;
    localparam logic [2:0] K_CLEAR   = 3'd2;
    localparam logic [2:0] K_READ    = 3'd3;
    localparam logic [2:0] K_REFRESH = 3'd4;
    localparam logic [2:0] K_TICK    = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] R_LED_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] R_BIT0_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] R_BIT0_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] R_BIT1_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] R_BIT1_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] R_RESET_LOW = 3'd5;

    // waveform phases
    localparam logic [1:0] PH_HIGH  = 2'd0;
    localparam logic [1:0] PH_LOW   = 2'd1;
    localparam logic [1:0] PH_LATCH = 2'd2;

    localparam logic [BIT_W-1:0] LAST_BIT = 5'd23;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in;

    typedef struct packed {
        logic       line_level;
        logic       busy_res;
        logic       frame_done;
        logic       accepted;
        logic       read_valid;
        logic [7:0] read_red;
        logic [7:0] read_green;
        logic [7:0] read_blue;
    } t_out;

    typedef struct packed {
        logic [8:0]       led_count;
        logic [DUR_W-1:0] bit0_high;
        logic [DUR_W-1:0] bit0_low;
        logic [DUR_W-1:0] bit1_high;
        logic [DUR_W-1:0] bit1_low;
        logic [DUR_W-1:0] reset_low;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic wr_pixel;
        logic sweep_init;
        logic sweep_wr;
        logic rd_idx;
        logic rd_first;
        logic rd_next;
        logic frame_start;
        logic tick;
        logic load_shift;
        logic res_load;
        logic res_acc;
        logic res_rv;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] kind;
        logic       sending;
        logic       idx_ok;
        logic       cnt_zero;
        logic       sweep_end;
        logic       tick_load;
    } t_stat;

    // duration of zero counts as one tick
    function automatic logic [DUR_W-1:0] dur(input logic [DUR_W-1:0] v);
        dur = (v == '0) ? DUR_W'(1) : v;
    endfunction

endpackage

/* rtl/lsps_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_cfg
// Configuration register file: strip length and waveform timings.
// ----------------------------------------------------------------------------
module lsps_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lsps_pkg::DUR_W-1:0]         i_cfg_data,
    output lsps_pkg::t_cfg                     o_cfg
);

    lsps_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_count <= 9'd1;
            r_cfg.bit0_high <= lsps_pkg::DUR_W'(12);
            r_cfg.bit0_low  <= lsps_pkg::DUR_W'(28);
            r_cfg.bit1_high <= lsps_pkg::DUR_W'(28);
            r_cfg.bit1_low  <= lsps_pkg::DUR_W'(12);
            r_cfg.reset_low <= lsps_pkg::DUR_W'(100);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lsps_pkg::R_LED_COUNT: r_cfg.led_count <= i_cfg_data[8:0];
                lsps_pkg::R_BIT0_HIGH: r_cfg.bit0_high <= i_cfg_data;
                lsps_pkg::R_BIT0_LOW:  r_cfg.bit0_low  <= i_cfg_data;
                lsps_pkg::R_BIT1_HIGH: r_cfg.bit1_high <= i_cfg_data;
                lsps_pkg::R_BIT1_LOW:  r_cfg.bit1_low  <= i_cfg_data;
                lsps_pkg::R_RESET_LOW: r_cfg.reset_low <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/lsps_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_dp
// Datapath: pixel store, fill sweep, bit serializer and result register.
// ----------------------------------------------------------------------------
module lsps_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lsps_pkg::t_in   i_cmd,
    input  lsps_pkg::t_cfg  i_cfg,
    input  lsps_pkg::t_ctl  i_ctl,
    output lsps_pkg::t_stat o_stat,
    output lsps_pkg::t_out  o_res
);

    localparam int IW = lsps_pkg::IDX_W;
    localparam int CW = lsps_pkg::CNT_W;
    localparam int DW = lsps_pkg::DUR_W;
    localparam int PW = lsps_pkg::PIX_W;

    logic [PW-1:0] mem [lsps_pkg::LED_MAX];
    logic [lsps_pkg::LED_MAX-1:0] r_vld;
    logic [PW-1:0] r_rdata;
    logic          r_rvld;

    logic [2:0]    r_kind;
    logic [IW-1:0] r_idx;
    logic [PW-1:0] r_word;

    logic                         r_sending;
    logic [CW-1:0]                r_pp;
    logic [lsps_pkg::BIT_W-1:0]   r_bp;
    logic [1:0]                   r_phase;
    logic [DW-1:0]                r_tc;
    logic [PW-1:0]                r_shift;
    logic                         r_level;
    logic                         r_fdone;
    logic [CW-1:0]                r_sweep;
    lsps_pkg::t_out               r_res;

    logic [CW-1:0] cnt;
    logic [CW-1:0] pp_inc;
    logic [DW-1:0] tc1;
    logic          one;
    logic          hi_end, lo_end, latch_end;
    logic          we, re;
    logic [IW-1:0] wa, ra;
    logic [PW-1:0] wd;
    logic [PW-1:0] rpix;

    always_comb begin
        if (i_cfg.led_count > CW'(lsps_pkg::LED_MAX)) begin
            cnt = CW'(lsps_pkg::LED_MAX);
        end else begin
            cnt = i_cfg.led_count;
        end
    end

    assign pp_inc    = r_pp + CW'(1);
    assign tc1       = r_tc + DW'(1);
    assign one       = r_shift[PW-1];
    assign hi_end    = tc1 >= lsps_pkg::dur(one ? i_cfg.bit1_high : i_cfg.bit0_high);
    assign lo_end    = tc1 >= lsps_pkg::dur(one ? i_cfg.bit1_low : i_cfg.bit0_low);
    assign latch_end = tc1 >= lsps_pkg::dur(i_cfg.reset_low);

    assign o_stat.kind      = r_kind;
    assign o_stat.sending   = r_sending;
    assign o_stat.idx_ok    = CW'(r_idx) < cnt;
    assign o_stat.cnt_zero  = cnt == '0;
    assign o_stat.sweep_end = r_sweep >= cnt;
    // end of a pixel with another one still to go
    assign o_stat.tick_load = (r_phase == lsps_pkg::PH_LOW) && lo_end
                              && (r_bp == lsps_pkg::LAST_BIT) && (pp_inc < cnt);

    // store ports
    assign we = i_ctl.wr_pixel || i_ctl.sweep_wr;
    assign wa = i_ctl.wr_pixel ? r_idx : r_sweep[IW-1:0];
    assign wd = (i_ctl.wr_pixel || r_kind == lsps_pkg::K_FILL) ? r_word : '0;
    assign re = i_ctl.rd_idx || i_ctl.rd_first || i_ctl.rd_next;

    always_comb begin
        if (i_ctl.rd_idx) begin
            ra = r_idx;
        end else if (i_ctl.rd_next) begin
            ra = pp_inc[IW-1:0];
        end else begin
            ra = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            r_rdata <= mem[ra];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (we) begin
                r_vld[wa] <= 1'b1;
            end
            if (re) begin
                r_rvld <= r_vld[ra];
            end
        end
    end

    assign rpix = r_rvld ? r_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_kind <= i_cmd.kind;
            r_idx  <= i_cmd.led_index;
            r_word <= {i_cmd.green, i_cmd.red, i_cmd.blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sweep_init) begin
            r_sweep <= '0;
        end else if (i_ctl.sweep_wr) begin
            r_sweep <= r_sweep + CW'(1);
        end
    end

    // serializer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending <= 1'b0;
            r_pp      <= '0;
            r_bp      <= '0;
            r_phase   <= lsps_pkg::PH_HIGH;
            r_tc      <= '0;
            r_shift   <= '0;
            r_level   <= 1'b0;
            r_fdone   <= 1'b0;
        end else begin
            if (i_ctl.capture) begin
                r_level <= 1'b0;
                r_fdone <= 1'b0;
            end
            if (i_ctl.frame_start) begin
                r_sending <= 1'b1;
                r_pp      <= '0;
                r_bp      <= '0;
                r_tc      <= '0;
                r_shift   <= '0;
                r_phase   <= (cnt == '0) ? lsps_pkg::PH_LATCH : lsps_pkg::PH_HIGH;
            end
            if (i_ctl.load_shift) begin
                r_shift <= rpix;
            end
            if (i_ctl.tick) begin
                r_tc    <= tc1;
                r_level <= r_phase == lsps_pkg::PH_HIGH;
                case (r_phase)
                    lsps_pkg::PH_HIGH: begin
                        if (hi_end) begin
                            r_phase <= lsps_pkg::PH_LOW;
                            r_tc    <= '0;
                        end
                    end
                    lsps_pkg::PH_LOW: begin
                        if (lo_end) begin
                            r_tc    <= '0;
                            r_phase <= lsps_pkg::PH_HIGH;
                            if (r_bp == lsps_pkg::LAST_BIT) begin
                                r_bp <= '0;
                                r_pp <= pp_inc;
                                if (pp_inc >= cnt) begin
                                    r_phase <= lsps_pkg::PH_LATCH;
                                    r_shift <= '0;
                                end
                            end else begin
                                r_bp    <= r_bp + lsps_pkg::BIT_W'(1);
                                r_shift <= {r_shift[PW-2:0], 1'b0};
                            end
                        end
                    end
                    default: begin
                        if (latch_end) begin
                            r_fdone   <= 1'b1;
                            r_sending <= 1'b0;
                            r_phase   <= lsps_pkg::PH_HIGH;
                            r_tc      <= '0;
                            r_pp      <= '0;
                            r_bp      <= '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_load) begin
            r_res.line_level <= r_level;
            r_res.busy_res   <= r_sending;
            r_res.frame_done <= r_fdone;
            r_res.accepted   <= i_ctl.res_acc;
            r_res.read_valid <= i_ctl.res_rv;
            r_res.read_red   <= i_ctl.res_rv ? rpix[15:8]  : 8'd0;
            r_res.read_green <= i_ctl.res_rv ? rpix[23:16] : 8'd0;
            r_res.read_blue  <= i_ctl.res_rv ? rpix[7:0]   : 8'd0;
        end
    end

    assign o_res = r_res;

endmodule

/* rtl/lsps_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_ctrl
// Command sequencer: decodes a word, drives the datapath, strobes the result.
// ----------------------------------------------------------------------------
module lsps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output logic            o_done,
    input  lsps_pkg::t_stat i_stat,
    output lsps_pkg::t_ctl  o_ctl
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_done, n_done;
    logic       r_acc, n_acc;
    logic       r_rv, n_rv;
    logic       r_load, n_load;

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_acc   = r_acc;
        n_rv    = r_rv;
        n_load  = r_load;
        o_ctl   = '0;
        o_ctl.capture = i_start && (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                    n_acc   = 1'b0;
                    n_rv    = 1'b0;
                    n_load  = 1'b0;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (i_stat.kind)
                    lsps_pkg::K_WRITE: begin
                        if (!i_stat.sending && i_stat.idx_ok) begin
                            o_ctl.wr_pixel = 1'b1;
                            n_acc          = 1'b1;
                        end
                    end
                    lsps_pkg::K_FILL, lsps_pkg::K_CLEAR: begin
                        if (!i_stat.sending) begin
                            o_ctl.sweep_init = 1'b1;
                            n_acc            = 1'b1;
                            n_state          = S_SWEEP;
                        end
                    end
                    lsps_pkg::K_READ: begin
                        if (i_stat.idx_ok) begin
                            o_ctl.rd_idx = 1'b1;
                            n_acc        = 1'b1;
                            n_rv         = 1'b1;
                        end
                    end
                    lsps_pkg::K_REFRESH: begin
                        if (!i_stat.sending) begin
                            o_ctl.frame_start = 1'b1;
                            n_acc             = 1'b1;
                            if (!i_stat.cnt_zero) begin
                                o_ctl.rd_first = 1'b1;
                                n_load         = 1'b1;
                            end
                        end
                    end
                    lsps_pkg::K_TICK: begin
                        if (i_stat.sending) begin
                            o_ctl.tick = 1'b1;
                            n_acc      = 1'b1;
                            if (i_stat.tick_load) begin
                                o_ctl.rd_next = 1'b1;
                                n_load        = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_SWEEP: begin
                if (i_stat.sweep_end) begin
                    n_state = S_RESP;
                end else begin
                    o_ctl.sweep_wr = 1'b1;
                end
            end
            S_RESP: begin
                o_ctl.res_load   = 1'b1;
                o_ctl.load_shift = r_load;
                o_ctl.res_acc    = r_acc;
                o_ctl.res_rv     = r_rv;
                n_done           = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_acc   <= 1'b0;
            r_rv    <= 1'b0;
            r_load  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_acc   <= n_acc;
            r_rv    <= n_rv;
            r_load  <= n_load;
        end
    end

endmodule

/* rtl/led_strip_pixel_serializer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_pixel_serializer
// One-wire LED strip driver: pixel store plus per-tick bit waveform generator.
//
//  channel   direction  handshake                  word
//  command   in         start / busy               i_cmd  (t_in)
//  result    out        o_done, one-cycle strobe   o_res  (t_out)
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A command goes from accept through execute and response states to the result
// strobe; fill and clear add a pixel sweep, as the store has one write port.
// The store needs no clearing pass after reset: per-entry valid bits read
// unwritten pixels as zero. The result cannot be stalled; it is shown for one
// cycle, during which the next command may already be accepted.
// ----------------------------------------------------------------------------
module led_strip_pixel_serializer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  lsps_pkg::t_in                   i_cmd,
    output logic                            o_done,
    output lsps_pkg::t_out                  o_res,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsps_pkg::DUR_W-1:0]      i_cfg_data
);

    lsps_pkg::t_cfg  cfg;
    lsps_pkg::t_ctl  ctl;
    lsps_pkg::t_stat stat;

    lsps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lsps_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_cfg   (cfg),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_res   (o_res)
    );

    lsps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

endmodule

/* verif/lsps_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_checker
// Watches the command, result and config channels of the LED strip pixel
// serializer. Keeps its own copy of the pixel store, the frame state and the
// registers, works out the result word of every accepted command and compares
// each result strobe field by field against the oldest outstanding word.
// ----------------------------------------------------------------------------
module lsps_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  lsps_pkg::t_in                   i_cmd,
    input  logic                            i_done,
    input  lsps_pkg::t_out                  i_res,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsps_pkg::DUR_W-1:0]      i_cfg_data,
    output int                              o_fail_count,
    output int                              o_words_due,
    output logic                            o_frame_on
);
    import lsps_pkg::*;

    logic [PIX_W-1:0] pix_mem [LED_MAX];
    logic             sending;
    logic [CNT_W-1:0] pix_ptr;
    logic [BIT_W-1:0] bit_ptr;
    logic [1:0]       phase;
    logic [DUR_W-1:0] tick_cnt;
    logic [PIX_W-1:0] shift_q;
    t_cfg             cfg;

    t_out             due_q [$];
    t_out             want;
    int               fails;

    // pixels actually in use
    function automatic logic [CNT_W-1:0] in_use();
        return (cfg.led_count > CNT_W'(LED_MAX)) ? CNT_W'(LED_MAX) : cfg.led_count;
    endfunction

    // a zero length still lasts one tick
    function automatic logic span_over(input logic [DUR_W-1:0] cnt,
                                       input logic [DUR_W-1:0] len);
        return cnt >= ((len == '0) ? DUR_W'(1) : len);
    endfunction

    task automatic clear_strip();
        int i;
        for (i = 0; i < LED_MAX; i++) pix_mem[IDX_W'(i)] = '0;
        sending  = 1'b0;
        pix_ptr  = '0;
        bit_ptr  = '0;
        phase    = PH_HIGH;
        tick_cnt = '0;
        shift_q  = '0;
        cfg.led_count = 9'd1;
        cfg.bit0_high = DUR_W'(12);
        cfg.bit0_low  = DUR_W'(28);
        cfg.bit1_high = DUR_W'(28);
        cfg.bit1_low  = DUR_W'(12);
        cfg.reset_low = DUR_W'(100);
    endtask

    function automatic t_out advance_strip(input t_in c);
        t_out             r;
        logic [CNT_W-1:0] n;
        logic [PIX_W-1:0] colour;
        logic [PIX_W-1:0] rd;
        logic             one;
        int               i;
        r      = '0;
        rd     = '0;
        n      = in_use();
        colour = {c.green, c.red, c.blue};
        case (c.kind)
            K_WRITE: begin
                if (!sending && CNT_W'(c.led_index) < n) begin
                    pix_mem[c.led_index] = colour;
                    r.accepted = 1'b1;
                end
            end
            K_FILL, K_CLEAR: begin
                if (!sending) begin
                    for (i = 0; i < int'(n); i++)
                        pix_mem[IDX_W'(i)] = (c.kind == K_FILL) ? colour : '0;
                    r.accepted = 1'b1;
                end
            end
            K_READ: begin
                if (CNT_W'(c.led_index) < n) begin
                    rd = pix_mem[c.led_index];
                    r.read_valid = 1'b1;
                    r.accepted   = 1'b1;
                end
            end
            K_REFRESH: begin
                if (!sending) begin
                    sending  = 1'b1;
                    pix_ptr  = '0;
                    bit_ptr  = '0;
                    tick_cnt = '0;
                    if (n == '0) begin
                        phase   = PH_LATCH;
                        shift_q = '0;
                    end else begin
                        phase   = PH_HIGH;
                        shift_q = pix_mem[0];
                    end
                    r.accepted = 1'b1;
                end
            end
            K_TICK: begin
                if (sending) begin
                    one        = shift_q[PIX_W-1];
                    r.accepted = 1'b1;
                    tick_cnt   = tick_cnt + DUR_W'(1);
                    if (phase == PH_HIGH) begin
                        r.line_level = 1'b1;
                        if (span_over(tick_cnt, one ? cfg.bit1_high : cfg.bit0_high)) begin
                            phase    = PH_LOW;
                            tick_cnt = '0;
                        end
                    end else if (phase == PH_LOW) begin
                        if (span_over(tick_cnt, one ? cfg.bit1_low : cfg.bit0_low)) begin
                            tick_cnt = '0;
                            phase    = PH_HIGH;
                            if (bit_ptr == LAST_BIT) begin
                                bit_ptr = '0;
                                pix_ptr = pix_ptr + CNT_W'(1);
                                // a shrunken count also ends the frame here
                                if (pix_ptr >= n) begin
                                    phase   = PH_LATCH;
                                    shift_q = '0;
                                end else begin
                                    shift_q = pix_mem[pix_ptr[IDX_W-1:0]];
                                end
                            end else begin
                                bit_ptr = bit_ptr + BIT_W'(1);
                                shift_q = shift_q << 1;
                            end
                        end
                    end else begin
                        if (span_over(tick_cnt, cfg.reset_low)) begin
                            r.frame_done = 1'b1;
                            sending  = 1'b0;
                            phase    = PH_HIGH;
                            tick_cnt = '0;
                            pix_ptr  = '0;
                            bit_ptr  = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.busy_res   = sending;
        r.read_red   = rd[15:8];
        r.read_green = rd[23:16];
        r.read_blue  = rd[7:0];
        return r;
    endfunction

    task automatic cmp_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            fails++;
        end
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_strip();
            due_q.delete();
        end else begin
            if (i_done) begin
                if (due_q.size() == 0) begin
                    $error("result word with none outstanding: %0h", i_res);
                    fails++;
                end else begin
                    want = due_q.pop_front();
                    cmp_field("line_level", 8'(want.line_level), 8'(i_res.line_level));
                    cmp_field("busy_res",   8'(want.busy_res),   8'(i_res.busy_res));
                    cmp_field("frame_done", 8'(want.frame_done), 8'(i_res.frame_done));
                    cmp_field("accepted",   8'(want.accepted),   8'(i_res.accepted));
                    cmp_field("read_valid", 8'(want.read_valid), 8'(i_res.read_valid));
                    cmp_field("read_red",   want.read_red,   i_res.read_red);
                    cmp_field("read_green", want.read_green, i_res.read_green);
                    cmp_field("read_blue",  want.read_blue,  i_res.read_blue);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    R_LED_COUNT: cfg.led_count = i_cfg_data[8:0];
                    R_BIT0_HIGH: cfg.bit0_high = i_cfg_data;
                    R_BIT0_LOW:  cfg.bit0_low  = i_cfg_data;
                    R_BIT1_HIGH: cfg.bit1_high = i_cfg_data;
                    R_BIT1_LOW:  cfg.bit1_low  = i_cfg_data;
                    R_RESET_LOW: cfg.reset_low = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) due_q.push_back(advance_strip(i_cmd));
        end
        o_words_due  <= due_q.size();
        o_frame_on   <= sending;
        o_fail_count <= fails;
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the LED strip pixel serializer. Directed commands cover the
// store edges, rejected commands during a frame, zero-length and maximum
// timings, saturated and empty strips and a count cut mid-frame; then random
// command streams under several pacing settings. Checking is in lsps_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import lsps_pkg::*;

    localparam logic [2:0] K_SPARE_LO   = 3'd6;
    localparam logic [2:0] K_SPARE_HI   = 3'd7;
    localparam int         PHASE_WORDS  = 100;
    localparam int         RUN_LIMIT_NS = 2_000_000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in                  i_cmd;
    logic                 o_done;
    t_out                 o_res;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DUR_W-1:0]     i_cfg_data;

    int                   fail_count;
    int                   words_due;
    logic                 frame_on;
    int                   idle_pct;
    int                   strip_len;
    int                   pace [4] = '{0, 53, 0, 11};

    led_strip_pixel_serializer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    lsps_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_done       (o_done),
        .i_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_words_due  (words_due),
        .o_frame_on   (frame_on)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic t_in pack_cmd(input logic [2:0] k, input logic [7:0] idx,
                                     input logic [7:0] red_v, input logic [7:0] green_v,
                                     input logic [7:0] blue_v);
        t_in c;
        c.kind      = k;
        c.led_index = idx;
        c.red       = red_v;
        c.green     = green_v;
        c.blue      = blue_v;
        return c;
    endfunction

    // start stays high when words follow back to back
    task automatic send_word(input t_in c);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_results();
        start <= 1'b0;
        do @(posedge i_clk); while (words_due != 0);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic setup_strip(input logic [DUR_W-1:0] count, input logic [DUR_W-1:0] b0h,
                               input logic [DUR_W-1:0] b0l, input logic [DUR_W-1:0] b1h,
                               input logic [DUR_W-1:0] b1l, input logic [DUR_W-1:0] rl);
        wait_results();
        cfg_put(R_LED_COUNT, count);
        cfg_put(R_BIT0_HIGH, b0h);
        cfg_put(R_BIT0_LOW,  b0l);
        cfg_put(R_BIT1_HIGH, b1h);
        cfg_put(R_BIT1_LOW,  b1l);
        cfg_put(R_RESET_LOW, rl);
        i_cfg_valid <= 1'b0;
        strip_len = (int'(count[8:0]) > LED_MAX) ? LED_MAX : int'(count[8:0]);
    endtask

    // tick until the frame in flight has latched
    task automatic finish_frame();
        wait_results();
        while (frame_on) begin
            send_word(pack_cmd(K_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), 8'($urandom_range(255))));
            wait_results();
        end
    endtask

    task automatic random_setup();
        int                pick;
        logic [DUR_W-1:0]  count;
        pick = $urandom_range(19);
        if (pick == 0)       count = '0;
        else if (pick == 1)  count = 15'h7E02;  // junk above the count bits
        else if (pick < 12)  count = 15'd1;
        else if (pick < 17)  count = 15'd2;
        else                 count = DUR_W'($urandom_range(4, 3));
        setup_strip(count, DUR_W'($urandom_range(2)), DUR_W'($urandom_range(2)),
                    DUR_W'($urandom_range(3)), DUR_W'($urandom_range(2)),
                    DUR_W'($urandom_range(4)));
    endtask

    task automatic make_random(output t_in c);
        int pick;
        pick        = $urandom_range(99);
        c.led_index = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                    : 8'($urandom_range(strip_len > 255 ? 255 : strip_len));
        c.red       = 8'($urandom_range(255));
        c.green     = 8'($urandom_range(255));
        c.blue      = 8'($urandom_range(255));
        if (frame_on && $urandom_range(99) < 75) c.kind = K_TICK;
        else if (pick < 22) c.kind = K_WRITE;
        else if (pick < 30) c.kind = K_FILL;
        else if (pick < 35) c.kind = K_CLEAR;
        else if (pick < 57) c.kind = K_READ;
        else if (pick < 75) c.kind = K_REFRESH;
        else if (pick < 95) c.kind = K_TICK;
        else c.kind = $urandom_range(1) ? K_SPARE_HI : K_SPARE_LO;
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("tb_top failed");
        $finish;
    end

    initial begin
        t_in c;
        int  ph;
        int  n;
        start       <= 1'b0;
        i_cmd       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        idle_pct    = 0;
        strip_len   = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one pixel
        send_word(pack_cmd(K_READ,  8'd0, 8'h00, 8'h00, 8'h00));
        send_word(pack_cmd(K_READ,  8'd1, 8'h00, 8'h00, 8'h00));
        send_word(pack_cmd(K_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF));
        send_word(pack_cmd(K_WRITE, 8'd1, 8'h11, 8'h22, 8'h33));
        send_word(pack_cmd(K_READ,  8'd0, 8'h00, 8'h00, 8'h00));
        send_word(pack_cmd(K_TICK,  8'd0, 8'h00, 8'h00, 8'h00));
        send_word(pack_cmd(K_SPARE_LO, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(pack_cmd(K_SPARE_HI, 8'h00, 8'h00, 8'h00, 8'h00));

        // full strip, zero and maximum lengths
        setup_strip(15'd256, 15'd0, 15'd1, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        send_word(pack_cmd(K_FILL,  8'd0,   8'hA5, 8'h5A, 8'hFF));
        send_word(pack_cmd(K_WRITE, 8'd255, 8'h12, 8'h34, 8'h56));
        send_word(pack_cmd(K_READ,  8'd255, 8'h00, 8'h00, 8'h00));
        send_word(pack_cmd(K_READ,  8'd128, 8'h00, 8'h00, 8'h00));
        send_word(pack_cmd(K_CLEAR, 8'd0,   8'h00, 8'h00, 8'h00));
        send_word(pack_cmd(K_READ,  8'd255, 8'h00, 8'h00, 8'h00));
        send_word(pack_cmd(K_WRITE, 8'd0,   8'h01, 8'h80, 8'h00));
        send_word(pack_cmd(K_REFRESH, 8'd0, 8'h00, 8'h00, 8'h00));
        // everything but reads and ticks bounces off a running frame
        send_word(pack_cmd(K_REFRESH, 8'd0, 8'h00, 8'h00, 8'h00));
        send_word(pack_cmd(K_WRITE, 8'd0,   8'h77, 8'h77, 8'h77));
        send_word(pack_cmd(K_FILL,  8'd0,   8'h77, 8'h77, 8'h77));
        send_word(pack_cmd(K_CLEAR, 8'd0,   8'h00, 8'h00, 8'h00));
        send_word(pack_cmd(K_READ,  8'd0,   8'h00, 8'h00, 8'h00));
        repeat (3) send_word(pack_cmd(K_TICK, 8'd0, 8'h00, 8'h00, 8'h00));
        // strip shrinks to nothing mid-frame: latch after this pixel
        setup_strip(15'd0, 15'd1, 15'd1, 15'd2, 15'd1, 15'd2);
        finish_frame();

        // empty strip: latch pulse only
        send_word(pack_cmd(K_REFRESH, 8'd0, 8'h00, 8'h00, 8'h00));
        send_word(pack_cmd(K_READ,  8'd0, 8'h00, 8'h00, 8'h00));
        finish_frame();
        send_word(pack_cmd(K_WRITE, 8'd0, 8'h55, 8'h55, 8'h55));
        send_word(pack_cmd(K_FILL,  8'd0, 8'h55, 8'h55, 8'h55));

        // count beyond the store saturates
        setup_strip(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'd1, 15'd1, 15'd1);
        send_word(pack_cmd(K_READ,  8'd255, 8'h00, 8'h00, 8'h00));
        send_word(pack_cmd(K_WRITE, 8'd255, 8'hFF, 8'h00, 8'hFF));
        send_word(pack_cmd(K_READ,  8'd255, 8'h00, 8'h00, 8'h00));

        for (ph = 0; ph < 4; ph++) begin
            idle_pct = pace[ph];
            random_setup();
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (n == PHASE_WORDS / 2) random_setup();
                make_random(c);
                send_word(c);
                if ($urandom_range(39) == 0) wait_results();
            end
            finish_frame();
        end

        wait_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && words_due == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
